/* src/cmfm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmfm_pkg
// Shared constants, types and codes for the capture median frequency meter.
// ----------------------------------------------------------------------------
package cmfm_pkg;

  // sizing
  localparam int SAMPLES      = 16;
  localparam int COUNTER_BITS = 16;

  localparam int CAP_W     = 16;                   // capture_time field width
  localparam int FREQ_W    = 32;                   // frequency / ref_freq width
  localparam int TICK_W    = 16;                   // timeout_ticks / tick counter
  localparam int CFG_IDX_W = 2;
  localparam int PERIOD_W  = COUNTER_BITS + 1;
  localparam int REM_W     = PERIOD_W + 1;
  localparam int IDX_W     = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int RANK_W    = $clog2(SAMPLES + 1);
  localparam int MED_RANK  = SAMPLES / 2;
  localparam int DIV_CNT_W = $clog2(FREQ_W);

  // register reset values
  localparam logic [FREQ_W-1:0] REF_FREQ_RST = FREQ_W'(1000000);
  localparam logic [TICK_W-1:0] TIMEOUT_RST  = TICK_W'(1000);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REF_FREQ = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = CFG_IDX_W'(1);

  // result status codes
  localparam logic STATUS_MEASURED = 1'b0;
  localparam logic STATUS_TIMEOUT  = 1'b1;

  // input item kinds
  localparam logic KIND_EDGE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEL_CMP,
    ST_SEL_CHK,
    ST_DIV,
    ST_PUSH
  } cmfm_state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;    // input item taken this cycle
    logic sel_cmp;   // compare candidate against all stored periods
    logic sel_chk;   // check candidate rank
    logic div_step;  // one restoring division step
    logic push;      // move pending result into the output register
  } cmfm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic tick_timeout;  // offered item is a tick that reaches the timeout
    logic run_done;      // offered item is the edge that completes a run
    logic sel_found;     // candidate is the median
    logic div_last;      // final division step
    logic out_free;      // output register can take a result
  } cmfm_status_t;

endpackage

/* src/capture_median_frequency_meter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capture_median_frequency_meter
// Reciprocal frequency meter with a median filter over captured periods.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  items carry either an edge capture (tuser = 0, tdata = capture
//         time) or one time tick (tuser = 1). Every edge after the reference
//         adds one period; the edge that completes SAMPLES periods ends a run.
//   out_* items carry the frequency (tdata) and the status (tuser):
//         measured ref_freq / median period, or 0 with timeout status.
//   cfg_* writes ref_freq (index 0) and timeout_ticks (index 1), taken at
//         the clock edge where cfg_we is high; write only while idle.
// Sequence:
//   an item that gives no result leaves the block idle. A timeout tick
//   goes straight to the hand-off. A run-ending edge steps through a compare
//   and a check state per median candidate tried (up to SAMPLES candidates),
//   then through the bit-serial divider and the hand-off.
// Reset and stall:
//   reset clears the run and restores the register defaults; the period
//   store needs no clearing. While a result waits in the output register,
//   items that give no result are still taken; an item that gives a result
//   holds intake until the output register is free.
// ----------------------------------------------------------------------------
module capture_median_frequency_meter
  import cmfm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FREQ_W-1:0]    cfg_wdata,
  // input items
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [CAP_W-1:0]     in_tdata,   // [15:0] capture_time
  input  logic                 in_tuser,   // [0] kind
  // result items
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [FREQ_W-1:0]    out_tdata,  // [31:0] frequency
  output logic                 out_tuser   // [0] status
);

  cmfm_cmd_t    cmd;
  cmfm_status_t status;

  // sequencer
  cmfm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath
  cmfm_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .status     (status)
  );

  // a timeout result never carries a frequency
  a_timeout_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == STATUS_TIMEOUT) |-> out_tdata == '0)
    else $error("timeout result with nonzero frequency");

  // controller issues at most one command per cycle
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.accept, cmd.sel_cmp, cmd.sel_chk, cmd.div_step, cmd.push}))
    else $error("overlapping datapath commands");

  // intake stops after an item that produces a result
  a_busy_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept && (status.tick_timeout || status.run_done) |=> !in_tready)
    else $error("intake open while a result is being produced");

  // a found median starts the divider
  a_found_divides: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sel_chk && status.sel_found |=> cmd.div_step)
    else $error("median found but division not started");

endmodule

/* src/cmfm_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmfm_ctrl
// Sequencer: item intake, median search, division and result hand-off.
// ----------------------------------------------------------------------------
module cmfm_ctrl
  import cmfm_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  cmfm_status_t status,
  output cmfm_cmd_t    cmd
);

  cmfm_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (status.tick_timeout) begin
            state_nxt = ST_PUSH;
          end else if (status.run_done) begin
            state_nxt = ST_SEL_CMP;
          end
        end
      end
      ST_SEL_CMP: state_nxt = ST_SEL_CHK;
      ST_SEL_CHK: begin
        if (status.sel_found) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_SEL_CMP;
        end
      end
      ST_DIV: begin
        if (status.div_last) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_tready = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      ST_SEL_CMP: cmd.sel_cmp  = 1'b1;
      ST_SEL_CHK: cmd.sel_chk  = 1'b1;
      ST_DIV:     cmd.div_step = 1'b1;
      ST_PUSH:    cmd.push     = status.out_free;
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

/* src/cmfm_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmfm_datapath
// Period capture, period store, median rank search, restoring divider,
// configuration registers and output register.
// ----------------------------------------------------------------------------
module cmfm_datapath
  import cmfm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FREQ_W-1:0]    cfg_wdata,
  // input item payload
  input  logic [CAP_W-1:0]     in_tdata,
  input  logic                 in_tuser,
  // result channel
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [FREQ_W-1:0]    out_tdata,
  output logic                 out_tuser,
  // control
  input  cmfm_cmd_t            cmd,
  output cmfm_status_t         status
);

  // configuration registers
  logic [FREQ_W-1:0] ref_freq_r;
  logic [TICK_W-1:0] timeout_r;

  // run state
  logic [COUNTER_BITS-1:0] last_cap_r;
  logic                    have_ref_r;
  logic [IDX_W-1:0]        count_r;
  logic [TICK_W-1:0]       tick_r;
  logic [PERIOD_W-1:0]     period_store_r [SAMPLES];

  // median search
  logic [IDX_W-1:0]    cand_idx_r;
  logic [PERIOD_W-1:0] cand_r;
  logic [SAMPLES-1:0]  lt_mask_r;
  logic [SAMPLES-1:0]  eq_mask_r;
  logic [PERIOD_W-1:0] median_r;

  // divider and pending result
  logic [REM_W-1:0]     rem_r;
  logic [FREQ_W-1:0]    quo_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic                 res_status_r;

  // output register
  logic              out_valid_r;
  logic [FREQ_W-1:0] out_freq_r;
  logic              out_status_r;

  logic [COUNTER_BITS-1:0] cap;
  logic [PERIOD_W-1:0]     diff;
  logic [PERIOD_W-1:0]     period;
  logic [TICK_W-1:0]       tick_inc;
  logic                    is_tick;
  logic                    tick_hit;
  logic                    run_done;
  logic [PERIOD_W-1:0]     cand_val;
  logic [RANK_W-1:0]       n_lt;
  logic [RANK_W:0]         n_le;
  logic [REM_W-1:0]        rem_sh;
  logic [REM_W-1:0]        med_ext;
  logic                    q_bit;

  // period of the offered edge, with a counter wrap adding one full span
  assign cap  = COUNTER_BITS'(in_tdata);
  assign diff = {1'b0, cap} - {1'b0, last_cap_r};
  assign period = (cap > last_cap_r) ? diff
                                     : diff + {1'b1, {COUNTER_BITS{1'b0}}};

  // tick timeout and run completion
  assign is_tick  = (in_tuser == KIND_TICK);
  assign tick_inc = tick_r + 1'b1;
  assign tick_hit = (tick_inc >= timeout_r);
  assign run_done = !is_tick && have_ref_r && (count_r == IDX_W'(SAMPLES - 1));

  // median rank check
  assign cand_val = period_store_r[cand_idx_r];
  assign n_lt = RANK_W'($countones(lt_mask_r));
  assign n_le = (RANK_W + 1)'(n_lt) + (RANK_W + 1)'($countones(eq_mask_r));

  // restoring division step
  assign rem_sh  = {rem_r[REM_W-2:0], quo_r[FREQ_W-1]};
  assign med_ext = REM_W'(median_r);
  assign q_bit   = (rem_sh >= med_ext);

  always_comb begin
    status.tick_timeout = is_tick && tick_hit;
    status.run_done     = run_done;
    status.sel_found    = (n_lt <= RANK_W'(MED_RANK)) &&
                          ((RANK_W + 1)'(MED_RANK) < n_le);
    status.div_last     = (div_cnt_r == DIV_CNT_W'(FREQ_W - 1));
    status.out_free     = !out_valid_r || out_tready;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_freq_r <= REF_FREQ_RST;
      timeout_r  <= TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REF_FREQ: ref_freq_r <= cfg_wdata;
        CFG_TIMEOUT:  timeout_r  <= TICK_W'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // run control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_cap_r <= '0;
      have_ref_r <= 1'b0;
      count_r    <= '0;
      tick_r     <= '0;
    end else if (cmd.accept) begin
      if (is_tick) begin
        tick_r <= tick_hit ? '0 : tick_inc;
      end else if (!have_ref_r) begin
        last_cap_r <= cap;
        have_ref_r <= 1'b1;
      end else begin
        last_cap_r <= cap;
        if (run_done) begin
          count_r    <= '0;
          have_ref_r <= 1'b0;
          tick_r     <= '0;
        end else begin
          count_r <= count_r + 1'b1;
        end
      end
    end
  end

  // period store
  always_ff @(posedge clk) begin
    if (cmd.accept && !is_tick && have_ref_r) begin
      period_store_r[count_r] <= period;
    end
  end

  // median search: compare one candidate against every stored period
  always_ff @(posedge clk) begin
    if (cmd.accept && run_done) begin
      cand_idx_r <= '0;
    end else if (cmd.sel_chk && !status.sel_found) begin
      cand_idx_r <= cand_idx_r + 1'b1;
    end
    if (cmd.sel_cmp) begin
      cand_r <= cand_val;
      for (int j = 0; j < SAMPLES; j++) begin
        lt_mask_r[j] <= (period_store_r[j] < cand_val);
        eq_mask_r[j] <= (period_store_r[j] == cand_val);
      end
    end
    if (cmd.sel_chk && status.sel_found) begin
      median_r <= cand_r;
    end
  end

  // divider, also holds the pending result
  always_ff @(posedge clk) begin
    if (cmd.accept && is_tick && tick_hit) begin
      quo_r        <= '0;
      res_status_r <= STATUS_TIMEOUT;
    end else if (cmd.sel_chk && status.sel_found) begin
      quo_r        <= ref_freq_r;
      rem_r        <= '0;
      div_cnt_r    <= '0;
      res_status_r <= STATUS_MEASURED;
    end else if (cmd.div_step) begin
      rem_r     <= q_bit ? (rem_sh - med_ext) : rem_sh;
      quo_r     <= {quo_r[FREQ_W-2:0], q_bit};
      div_cnt_r <= div_cnt_r + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_freq_r   <= quo_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_freq_r;
  assign out_tuser  = out_status_r;

endmodule

/* tb/capture_median_frequency_meter_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// capture_median_frequency_meter_tb
// Self-checking bench for the median-filtered reciprocal frequency meter.
// Edge captures and time ticks go in on the input stream. A model in the
// bench keeps its own run state and predicts each reading: ref_freq divided
// by the median period, or a zero timeout reading. Directed corner items come
// first. Random runs of edges with ticks and noise follow, under several
// register settings and sender and receiver stall mixes. One long output
// hold-off is included.
// ----------------------------------------------------------------------------
module capture_median_frequency_meter_tb
  import cmfm_pkg::*;
;

  // one reading on the output stream
  typedef struct packed {
    logic [FREQ_W-1:0] frequency;
    logic              status;
  } reading_t;

  // how the periods of a random run are chosen
  typedef enum int {
    RUN_STEADY,
    RUN_SCATTER,
    RUN_FAST,
    RUN_EXTREME
  } run_shape_t;

  localparam int SETTLE_CYCLES   = 4 * SAMPLES + 40;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DIRECTED_EDGES  = SAMPLES + 1;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = CFG_REF_FREQ;
  logic [FREQ_W-1:0]    cfg_wdata  = '0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [CAP_W-1:0]     in_tdata   = '0;  // [15:0] capture_time
  logic                 in_tuser   = KIND_EDGE;  // [0] kind
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [FREQ_W-1:0]    out_tdata;  // [31:0] frequency
  logic                 out_tuser;  // [0] status

  // stall mix and bookkeeping
  int gap_pct    = 0;
  int stall_pct  = 0;
  int hold_len   = 0;
  int n_items    = 0;
  int n_measured = 0;
  int n_timeouts = 0;
  int n_settings = 0;
  int n_errors   = 0;

  reading_t expected_readings[$];

  // meter model state
  logic [FREQ_W-1:0]   ref_freq_q;
  logic [TICK_W-1:0]   timeout_q;
  logic [CAP_W-1:0]    last_cap;
  logic                have_ref;
  logic [PERIOD_W-1:0] periods[SAMPLES];
  int                  n_periods;
  logic [TICK_W-1:0]   ticks_since;

  capture_median_frequency_meter i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // advance the meter model by one item, queue the reading it gives
  function automatic void predict_reading(logic kind, logic [CAP_W-1:0] cap);
    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W-1:0] median;
    logic [PERIOD_W-1:0] ranked[$];
    reading_t            r;
    if (kind == KIND_TICK) begin
      ticks_since = ticks_since + 1'b1;
      if (ticks_since >= timeout_q) begin
        ticks_since = '0;
        r.frequency = '0;
        r.status    = STATUS_TIMEOUT;
        expected_readings.push_back(r);
      end
      return;
    end
    // first edge of a run only sets the reference
    if (!have_ref) begin
      last_cap = cap;
      have_ref = 1'b1;
      return;
    end
    // equal captures count as one full counter wrap
    if (cap > last_cap)
      period = PERIOD_W'(cap) - PERIOD_W'(last_cap);
    else
      period = PERIOD_W'(cap) + (PERIOD_W'(1) << COUNTER_BITS) - PERIOD_W'(last_cap);
    last_cap = cap;
    periods[n_periods] = period;
    n_periods++;
    if (n_periods < SAMPLES)
      return;
    // run complete: median of the sorted periods
    foreach (periods[i])
      ranked.push_back(periods[i]);
    ranked.sort();
    median      = ranked[MED_RANK];
    r.frequency = (median != '0) ? ref_freq_q / FREQ_W'(median) : '0;
    r.status    = STATUS_MEASURED;
    expected_readings.push_back(r);
    n_periods   = 0;
    have_ref    = 1'b0;
    ticks_since = '0;
  endfunction

  // receiver: check each accepted reading, then drive ready for the next edge
  always @(posedge clk) begin
    reading_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_readings.size() == 0) begin
        $error("unexpected reading: frequency %0d, status %0d", out_tdata, out_tuser);
        n_errors++;
      end else begin
        exp_r = expected_readings.pop_front();
        if (out_tdata !== exp_r.frequency) begin
          $error("frequency mismatch: expected %0d, got %0d", exp_r.frequency, out_tdata);
          n_errors++;
        end
        if (out_tuser !== exp_r.status) begin
          $error("status mismatch: expected %0d, got %0d", exp_r.status, out_tuser);
          n_errors++;
        end
        if (exp_r.status == STATUS_TIMEOUT)
          n_timeouts++;
        else
          n_measured++;
      end
    end
    if (hold_len > 0) begin
      out_tready <= 1'b0;
      hold_len   <= hold_len - 1;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // offer one item, with a random gap first, and predict it once taken
  task automatic send_item(logic kind, logic [CAP_W-1:0] cap);
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= cap;
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
    predict_reading(kind, cap);
    n_items++;
  endtask

  // stop sending, wait for every reading, then let the block settle
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_readings.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write both registers; only called while the block is idle
  task automatic apply_settings(logic [FREQ_W-1:0] ref_freq, logic [TICK_W-1:0] timeout);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_REF_FREQ;
    cfg_wdata <= ref_freq;
    @(posedge clk);
    cfg_index <= CFG_TIMEOUT;
    cfg_wdata <= FREQ_W'(timeout);
    @(posedge clk);
    cfg_we     <= 1'b0;
    ref_freq_q = ref_freq;
    timeout_q  = timeout;
    n_settings++;
  endtask

  // one run: a reference edge capture, then one per period until SAMPLES periods, ticks sprinkled in
  task automatic send_run(int tick_pct);
    run_shape_t       shape;
    logic [CAP_W-1:0] cap;
    int               base;
    int               delta;
    shape = run_shape_t'($urandom_range(3));
    cap   = CAP_W'($urandom);
    base  = (shape == RUN_FAST) ? $urandom_range(1, 8) : $urandom_range(1, 65535);
    for (int i = 0; i <= SAMPLES; i++) begin
      if (i > 0) begin
        case (shape)
          RUN_STEADY:  delta = base + $urandom_range(0, 16) - 8;
          RUN_SCATTER: delta = $urandom;
          RUN_FAST:    delta = base + $urandom_range(0, 2);
          default: begin
            case ($urandom_range(3))
              0:       delta = 0;
              1:       delta = 1;
              2:       delta = 65535;
              default: delta = $urandom;
            endcase
          end
        endcase
        cap = cap + CAP_W'(delta);
      end
      if ($urandom_range(99) < tick_pct)
        repeat ($urandom_range(1, 3)) send_item(KIND_TICK, CAP_W'($urandom));
      send_item(KIND_EDGE, cap);
    end
  endtask

  // corner captures, equal captures, wraps, a timeout mid-run, zero settings
  task automatic test_directed_corners();
    logic [CAP_W-1:0] caps[DIRECTED_EDGES];
    caps = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0001, 16'h8000,
             16'h7FFF, 16'h8000, 16'h8064, 16'h80C8, 16'h812C, 16'h8190,
             16'h81F4, 16'h8258, 16'h82BC, 16'h8320, 16'h8384};
    gap_pct   = 0;
    stall_pct = 0;
    foreach (caps[i])
      send_item(KIND_EDGE, caps[i]);
    send_item(KIND_TICK, 16'hFFFF);
    wait_drained();
    // timeout in the middle of a run keeps the periods collected so far
    apply_settings(REF_FREQ_RST, 16'd2);
    send_item(KIND_EDGE, 16'h1234);
    send_item(KIND_TICK, 16'h0000);
    send_item(KIND_TICK, 16'h5555);
    send_item(KIND_EDGE, 16'hAAAA);
    send_item(KIND_TICK, 16'h0000);
    wait_drained();
    // zero timeout: every tick times out
    apply_settings('0, '0);
    send_item(KIND_TICK, 16'h0000);
    send_item(KIND_TICK, 16'hFFFF);
  endtask

  // mostly well-formed runs, some random noise items
  task automatic test_random_traffic(int n, int gap, int stall, int tick_pct);
    int start;
    gap_pct   = gap;
    stall_pct = stall;
    start     = n_items;
    while (n_items - start < n) begin
      if ($urandom_range(99) < 75)
        send_run(tick_pct);
      else
        repeat ($urandom_range(1, 5)) send_item(1'($urandom), CAP_W'($urandom));
    end
  endtask

  // receiver holds off while timeout ticks keep coming, so intake stalls
  task automatic test_output_backpressure();
    apply_settings(REF_FREQ_RST, 16'd1);
    gap_pct   = 0;
    stall_pct = 0;
    hold_len <= HOLD_OFF_CYCLES;
    repeat (30) send_item(KIND_TICK, CAP_W'($urandom));
    send_run(0);
  endtask

  // run limit
  initial begin
    #5ms;
    $display("** capture_median_frequency_meter: FAILED **");
    $finish;
  end

  // test sequence
  initial begin
    ref_freq_q  = REF_FREQ_RST;
    timeout_q   = TIMEOUT_RST;
    last_cap    = '0;
    have_ref    = 1'b0;
    n_periods   = 0;
    ticks_since = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_corners();
    wait_drained();
    apply_settings(REF_FREQ_RST, 16'd20);
    test_random_traffic(350, 0, 0, 30);
    wait_drained();
    apply_settings('1, '1);
    test_random_traffic(350, 81, 0, 20);
    wait_drained();
    apply_settings(32'd1, 16'd1);
    test_random_traffic(350, 0, 81, 15);
    wait_drained();
    apply_settings(FREQ_W'($urandom), TICK_W'($urandom_range(1, 64)));
    test_random_traffic(350, 8, 8, 30);
    wait_drained();
    apply_settings('0, '0);
    test_random_traffic(100, 8, 8, 10);
    wait_drained();
    test_output_backpressure();
    wait_drained();

    $display("sent %0d items over %0d register settings", n_items, n_settings);
    $display("checked %0d measured readings and %0d timeout readings", n_measured, n_timeouts);
    if (n_errors == 0) begin
      $display("** capture_median_frequency_meter: PASSED **");
    end else begin
      $display("** capture_median_frequency_meter: FAILED **");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/cmfm_pkg.sv
src/cmfm_ctrl.sv
src/cmfm_datapath.sv
src/capture_median_frequency_meter.sv
tb/capture_median_frequency_meter_tb.sv
